// ===== src/pla_pkg.sv =====
// pla_pkg: shared field widths, request and status codes and reset constants
// for the positional array list
// no dependencies
package pla_pkg;

    // fixed field widths
    localparam int DATA_W = 32;
    localparam int POS_W  = 6;
    localparam int CNT_W  = 7;
    localparam int REQ_W  = 2;

    // request codes
    typedef logic [REQ_W-1:0] t_req;
    localparam t_req REQ_INSERT = 2'd0;
    localparam t_req REQ_REMOVE = 2'd1;
    localparam t_req REQ_GET    = 2'd2;

    // status codes
    localparam logic STAT_OK   = 1'b0;
    localparam logic STAT_FAIL = 1'b1;

    // capacity after reset
    localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

endpackage

// ===== src/pla_ram.sv =====
// pla_ram: generic single-clock ram, one write port and one read port,
// read data registered; contents undefined until written
// no dependencies
module pla_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/positional_array_list.sv =====
// positional_array_list: bounded ordered list of signed 32-bit values
// with insert, remove and get at a position
// depends on pla_pkg and pla_ram
//
// Usage:
//   Requests enter on the in channel (i_in_valid / o_in_ready) with a request
//   type, a position and a data word. Each request gives exactly one result
//   word on the out channel (o_out_valid / i_out_ready): read value, status and
//   the list length after the request.
//   The entries live in one ram with registered read. An insert or remove moves
//   N entries (N = length - position, or one less for a remove), one ram read
//   and one write per cycle; an insert then writes its new entry. A get reads
//   one entry and a failed request touches no entry. One request is worked on
//   at a time; the next request is taken as soon as the result sits in the
//   output register, even while the receiver stalls it. A stalled result holds
//   until taken, and the block then takes no new request after the one behind
//   it until it drains. Reset empties the list and sets capacity to 64; no
//   clearing pass is needed. Capacity (i_cfg_we / i_cfg_wdata) must be written
//   only while the block is idle; the block itself does not enforce this.
module positional_array_list #(
    parameter int DEPTH = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               i_cfg_we,
    input  logic [pla_pkg::CNT_W-1:0]          i_cfg_wdata,
    // request channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [pla_pkg::REQ_W-1:0]          i_req_type,
    input  logic [pla_pkg::POS_W-1:0]          i_position,
    input  logic signed [pla_pkg::DATA_W-1:0]  i_data_in,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [pla_pkg::DATA_W-1:0]  o_read_value,
    output logic                               o_status,
    output logic [pla_pkg::CNT_W-1:0]          o_length
);

    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntMax    = (1 << pla_pkg::CNT_W) - 1;
    localparam int LimMaxInt = (DEPTH > CntMax) ? CntMax : DEPTH;
    localparam logic [pla_pkg::CNT_W-1:0] LIM_MAX = LimMaxInt[pla_pkg::CNT_W-1:0];

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_GETW,
        S_DONE
    } t_state;

    t_state                            r_state, n_state;
    logic [pla_pkg::CNT_W-1:0]         r_cap, n_cap;
    logic [pla_pkg::CNT_W-1:0]         r_count, n_count;
    pla_pkg::t_req                     r_op, n_op;
    logic [AW-1:0]                     r_pos, n_pos;
    logic signed [pla_pkg::DATA_W-1:0] r_data, n_data;
    logic [AW-1:0]                     r_src, n_src;
    logic [AW-1:0]                     r_wdst, n_wdst;
    logic [pla_pkg::CNT_W-1:0]         r_left, n_left;
    logic                              r_rd_vld, n_rd_vld;
    logic signed [pla_pkg::DATA_W-1:0] r_val, n_val;
    logic                              r_stat, n_stat;
    logic                              r_ovalid, n_ovalid;
    logic signed [pla_pkg::DATA_W-1:0] r_oval, n_oval;
    logic                              r_ostat, n_ostat;
    logic [pla_pkg::CNT_W-1:0]         r_olen, n_olen;

    logic [pla_pkg::CNT_W-1:0] c_lim;
    logic [pla_pkg::CNT_W-1:0] c_pos;
    logic                      c_acc;
    logic                      c_ok;
    logic                      c_issue;
    logic                      c_fin;

    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [pla_pkg::DATA_W-1:0] ram_wdata;
    logic [AW-1:0]             ram_raddr;
    logic [pla_pkg::DATA_W-1:0] ram_rdata;

    // entry store
    pla_ram #(
        .WIDTH (pla_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // request check against current count and limit
    always_comb begin
        c_lim = (r_cap < LIM_MAX) ? r_cap : LIM_MAX;
        c_pos = {1'b0, i_position};
        c_acc = i_in_valid && o_in_ready;
        case (i_req_type)
            pla_pkg::REQ_INSERT: c_ok = (r_count < c_lim) && (c_pos <= r_count);
            pla_pkg::REQ_REMOVE: c_ok = (c_pos < r_count);
            pla_pkg::REQ_GET:    c_ok = (c_pos < r_count);
            default:             c_ok = 1'b0;
        endcase
    end

    // shift sequencer ram controls: read one entry ahead, write it back moved
    always_comb begin
        c_issue   = (r_state == S_SHIFT) && (r_left != '0);
        c_fin     = (r_state == S_SHIFT) && (r_left == '0) && !r_rd_vld;
        ram_raddr = (r_state == S_IDLE) ? AW'(i_position) : r_src;
        ram_we    = (r_state == S_SHIFT) &&
                    (r_rd_vld || (c_fin && (r_op == pla_pkg::REQ_INSERT)));
        ram_waddr = r_rd_vld ? r_wdst : r_pos;
        ram_wdata = r_rd_vld ? ram_rdata : r_data;
    end

    // next state
    always_comb begin
        n_state  = r_state;
        n_cap    = i_cfg_we ? i_cfg_wdata : r_cap;
        n_count  = r_count;
        n_op     = r_op;
        n_pos    = r_pos;
        n_data   = r_data;
        n_src    = r_src;
        n_wdst   = r_wdst;
        n_left   = r_left;
        n_rd_vld = 1'b0;
        n_val    = r_val;
        n_stat   = r_stat;
        n_ovalid = r_ovalid && !i_out_ready;
        n_oval   = r_oval;
        n_ostat  = r_ostat;
        n_olen   = r_olen;

        case (r_state)
            S_IDLE: begin
                if (c_acc) begin
                    n_op   = i_req_type;
                    n_pos  = AW'(i_position);
                    n_data = i_data_in;
                    n_val  = '0;
                    n_stat = c_ok ? pla_pkg::STAT_OK : pla_pkg::STAT_FAIL;
                    n_state = S_DONE;
                    if (c_ok) begin
                        case (i_req_type)
                            pla_pkg::REQ_INSERT: begin
                                n_count = r_count + 7'd1;
                                n_left  = r_count - c_pos;
                                n_src   = AW'(r_count - 7'd1);
                                n_state = S_SHIFT;
                            end
                            pla_pkg::REQ_REMOVE: begin
                                n_count = r_count - 7'd1;
                                n_left  = r_count - c_pos - 7'd1;
                                n_src   = AW'(c_pos + 7'd1);
                                n_state = S_SHIFT;
                            end
                            pla_pkg::REQ_GET: begin
                                n_state = S_GETW;
                            end
                            default: begin
                                n_state = S_DONE;
                            end
                        endcase
                    end
                end
            end
            S_SHIFT: begin
                if (c_issue) begin
                    n_rd_vld = 1'b1;
                    n_left   = r_left - 7'd1;
                    if (r_op == pla_pkg::REQ_INSERT) begin
                        n_src  = r_src - AW'(1);
                        n_wdst = r_src + AW'(1);
                    end else begin
                        n_src  = r_src + AW'(1);
                        n_wdst = r_src - AW'(1);
                    end
                end
                if (c_fin) begin
                    n_state = S_DONE;
                end
            end
            S_GETW: begin
                n_val   = ram_rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    n_ovalid = 1'b1;
                    n_oval   = r_val;
                    n_ostat  = r_stat;
                    n_olen   = r_count;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cap    <= pla_pkg::CAP_RESET;
            r_count  <= '0;
            r_left   <= '0;
            r_rd_vld <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cap    <= n_cap;
            r_count  <= n_count;
            r_left   <= n_left;
            r_rd_vld <= n_rd_vld;
            r_ovalid <= n_ovalid;
        end
        r_op    <= n_op;
        r_pos   <= n_pos;
        r_data  <= n_data;
        r_src   <= n_src;
        r_wdst  <= n_wdst;
        r_val   <= n_val;
        r_stat  <= n_stat;
        r_oval  <= n_oval;
        r_ostat <= n_ostat;
        r_olen  <= n_olen;
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_ovalid;
    assign o_read_value = r_oval;
    assign o_status     = r_ostat;
    assign o_length     = r_olen;

    // count never passes the largest possible limit
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LIM_MAX)
        else $error("list count above limit");

    // a successful insert grows the list by one
    a_insert_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_acc && c_ok && (i_req_type == pla_pkg::REQ_INSERT))
        |=> (r_count == $past(r_count) + 7'd1))
        else $error("insert did not grow count");

    // moves remain only while shifting
    a_left_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_SHIFT) |-> (r_left == '0))
        else $error("pending moves outside shift");

    // a failed word carries a zero value
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == pla_pkg::STAT_FAIL)) |-> (o_read_value == '0))
        else $error("failed word with nonzero value");

endmodule

// ===== bench/tb_positional_array_list.sv =====
// tb_positional_array_list: self-checking bench for the positional array list
// drives request words, predicts each reply word and compares it field by field
// depends on pla_pkg and positional_array_list
module tb_positional_array_list;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = 64;
    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 8;
    localparam int DRAIN_CYCLES = DEPTH + 8;
    localparam int QUIET_LIMIT  = 2000;
    localparam int MAX_GAP      = 8;
    localparam int PRINT_LIMIT  = 40;

    // request code the block does not know
    localparam pla_pkg::t_req REQ_BAD = 2'd3;

    typedef logic [pla_pkg::POS_W-1:0]  t_pos;
    typedef logic [pla_pkg::DATA_W-1:0] t_word;

    typedef struct packed {
        logic signed [pla_pkg::DATA_W-1:0] value;
        logic                              status;
        logic [pla_pkg::CNT_W-1:0]         length;
    } t_list_reply;

    // dut ports
    logic                              i_clk       = 1'b0;
    logic                              i_rst_n     = 1'b0;
    logic                              i_cfg_we    = 1'b0;
    logic [pla_pkg::CNT_W-1:0]         i_cfg_wdata = '0;
    logic                              i_in_valid  = 1'b0;
    logic                              o_in_ready;
    logic [pla_pkg::REQ_W-1:0]         i_req_type  = '0;
    logic [pla_pkg::POS_W-1:0]         i_position  = '0;
    logic signed [pla_pkg::DATA_W-1:0] i_data_in   = '0;
    logic                              o_out_valid;
    logic                              i_out_ready = 1'b0;
    logic signed [pla_pkg::DATA_W-1:0] o_read_value;
    logic                              o_status;
    logic [pla_pkg::CNT_W-1:0]         o_length;

    // list mirror
    t_word                     list_vals [DEPTH];
    int                        list_len;
    logic [pla_pkg::CNT_W-1:0] cap_model;
    t_list_reply               replies_due [$];

    // bench control
    bit          gaps_on     = 1'b1;
    int          gap_pending = 0;
    int          ready_hold  = 0;
    int          quiet_cycles = 0;
    int          mismatches  = 0;
    t_list_reply due;

    positional_array_list #(
        .DEPTH(DEPTH)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_req_type   (i_req_type),
        .i_position   (i_position),
        .i_data_in    (i_data_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_read_value (o_read_value),
        .o_status     (o_status),
        .o_length     (o_length)
    );

    // clock
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // one line per mismatch, printing capped
    task automatic report_mismatch(input string what, input t_word got, input t_word want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT) begin
            $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got,
                     want);
        end
    endtask

    // apply one request to the mirror and return the reply it should give
    function automatic t_list_reply predict_list_op(input pla_pkg::t_req req,
                                                    input t_pos pos,
                                                    input t_word data);
        t_list_reply r;
        int          lim;
        int          p;
        lim = (cap_model < DEPTH) ? int'(cap_model) : DEPTH;
        p = int'(pos);
        r.value = '0;
        r.status = pla_pkg::STAT_FAIL;
        case (req)
            pla_pkg::REQ_INSERT: begin
                if (lim > 0 && p <= list_len && p <= lim - 1 && list_len < lim) begin
                    for (int i = list_len; i > p; i--) list_vals[i] = list_vals[i-1];
                    list_vals[p] = data;
                    list_len++;
                    r.status = pla_pkg::STAT_OK;
                end
            end
            pla_pkg::REQ_REMOVE: begin
                if (p < list_len) begin
                    for (int i = p; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
                    list_len--;
                    r.status = pla_pkg::STAT_OK;
                end
            end
            pla_pkg::REQ_GET: begin
                if (p < list_len) begin
                    r.value = list_vals[p];
                    r.status = pla_pkg::STAT_OK;
                end
            end
            default: ;
        endcase
        r.length = list_len[pla_pkg::CNT_W-1:0];
        return r;
    endfunction

    // send one request word, hold it until taken, then log its reply
    task automatic send_request(input pla_pkg::t_req req, input t_pos pos,
                                input t_word data);
        repeat (gap_pending) @(posedge i_clk);
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_position <= pos;
        i_data_in  <= data;
        do @(posedge i_clk); while (!o_in_ready);
        replies_due.push_back(predict_list_op(req, pos, data));
        // gap before the next word; valid stays up when there is none
        gap_pending = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap_pending != 0) i_in_valid <= 1'b0;
    endtask

    // wait for every reply, then let the block settle
    task automatic wait_drained();
        if (gap_pending == 0) i_in_valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // capacity is only written while the block is idle
    task automatic write_capacity(input logic [pla_pkg::CNT_W-1:0] cap);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cap;
        @(posedge i_clk);
        cap_model = cap;
        i_cfg_we <= 1'b0;
    endtask

    // empty list, data extremes, front/middle/end inserts, bad positions, bad code
    task automatic test_basic_ops();
        send_request(pla_pkg::REQ_GET,    6'd0,  32'h0000_0000);
        send_request(pla_pkg::REQ_REMOVE, 6'd0,  32'hFFFF_FFFF);
        send_request(REQ_BAD,             6'd0,  32'h1234_5678);
        send_request(pla_pkg::REQ_INSERT, 6'd1,  32'h5555_5555);
        send_request(pla_pkg::REQ_INSERT, 6'd0,  32'h7FFF_FFFF);
        send_request(pla_pkg::REQ_INSERT, 6'd0,  32'h8000_0000);
        send_request(pla_pkg::REQ_INSERT, 6'd2,  32'hFFFF_FFFF);
        send_request(pla_pkg::REQ_INSERT, 6'd1,  32'h0000_0000);
        send_request(pla_pkg::REQ_INSERT, 6'd63, 32'hAAAA_AAAA);
        for (int i = 0; i < 4; i++) send_request(pla_pkg::REQ_GET, i[pla_pkg::POS_W-1:0], 32'h0);
        send_request(pla_pkg::REQ_GET,    6'd63, 32'h0);
        send_request(pla_pkg::REQ_REMOVE, 6'd1,  32'h0);
        send_request(pla_pkg::REQ_GET,    6'd1,  32'h0);
        send_request(pla_pkg::REQ_REMOVE, 6'd63, 32'h0);
    endtask

    // capacity below the count, full list, zero and above depth
    task automatic test_capacity_edges();
        write_capacity(7'd2);
        send_request(pla_pkg::REQ_INSERT, 6'd0, 32'h0BAD_0001);
        send_request(pla_pkg::REQ_REMOVE, 6'd0, 32'h0);
        send_request(pla_pkg::REQ_INSERT, 6'd1, 32'h0BAD_0002);
        send_request(pla_pkg::REQ_GET,    6'd1, 32'h0);
        write_capacity(7'd0);
        send_request(pla_pkg::REQ_INSERT, 6'd0, 32'h0BAD_0003);
        send_request(pla_pkg::REQ_GET,    6'd0, 32'h0);
        send_request(pla_pkg::REQ_REMOVE, 6'd0, 32'h0);
        write_capacity(7'd127);
        send_request(pla_pkg::REQ_INSERT, 6'd1, 32'h0BAD_0004);
    endtask

    // random traffic: fill then drain, mostly in-range positions
    task automatic test_random_traffic(input logic [pla_pkg::CNT_W-1:0] cap, input int items,
                                       input bit with_gaps);
        int            roll;
        bit            filling;
        pla_pkg::t_req req;
        t_pos          pos;
        write_capacity(cap);
        gaps_on = with_gaps;
        for (int n = 0; n < items; n++) begin
            filling = (n % 240) < 120;
            roll = $urandom_range(0, 99);
            if (roll < 3) req = REQ_BAD;
            else if (roll < (filling ? 78 : 18)) req = pla_pkg::REQ_INSERT;
            else if (roll < (filling ? 88 : 75)) req = pla_pkg::REQ_REMOVE;
            else req = pla_pkg::REQ_GET;
            if ($urandom_range(0, 9) == 0) pos = t_pos'($urandom_range(0, DEPTH - 1));
            else if (req == pla_pkg::REQ_INSERT)
                pos = (list_len >= DEPTH) ? t_pos'(DEPTH - 1)
                                          : t_pos'($urandom_range(0, list_len));
            else pos = (list_len == 0) ? '0 : t_pos'($urandom_range(0, list_len - 1));
            send_request(req, pos, $urandom());
        end
    endtask

    // reply checker with random receiver stalls
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (replies_due.size() == 0) begin
                report_mismatch("unexpected reply length", t_word'(o_length), '0);
            end else begin
                due = replies_due.pop_front();
                if (o_read_value !== due.value) report_mismatch("read_value", o_read_value,
                                                                due.value);
                if (o_status !== due.status) report_mismatch("status", t_word'(o_status),
                                                             t_word'(due.status));
                if (o_length !== due.length) report_mismatch("length", t_word'(o_length),
                                                             t_word'(due.length));
            end
            ready_hold = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
            i_out_ready <= (ready_hold == 0);
        end else if (!i_out_ready) begin
            if (ready_hold > 0) ready_hold--;
            if (ready_hold == 0) i_out_ready <= 1'b1;
        end
    end

    // watchdog on cycles where no word moves
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // reset, tests in turn, final verdict
    initial begin
        for (int i = 0; i < DEPTH; i++) list_vals[i] = '0;
        list_len = 0;
        cap_model = pla_pkg::CAP_RESET;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_ops();
        test_capacity_edges();
        test_random_traffic(7'd64,  240, 1'b1);
        test_random_traffic(7'd127, 240, 1'b1);
        test_random_traffic(7'd1,   120, 1'b1);
        test_random_traffic(7'd0,    60, 1'b1);
        test_random_traffic(7'd7,   160, 1'b1);
        test_random_traffic(7'd33,  200, 1'b1);
        test_random_traffic(7'd64,  240, 1'b0);
        test_random_traffic(7'd64,  120, 1'b1);
        test_random_traffic(7'd9,   200, 1'b1);

        wait_drained();
        if (replies_due.size() != 0) report_mismatch("replies missing", replies_due.size(), 0);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
